// File: sv/zn_tune_pkg.sv
// shared types, constants and microcode table of the ultimate-gain autotuner
`timescale 1ns / 1ps
`default_nettype none
package zn_tune_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int TICK_W    = 16;
   localparam int GAIN_W    = 16;
   localparam int AMP_W     = 17;
   localparam int KP_W      = 24;
   localparam int KD_W      = 37;
   localparam int PROD_W    = KP_W + TICK_W;
   localparam int DIV_W     = 26;
   localparam int DEN_W     = TICK_W + 1;
   localparam int CNT_W     = $clog2(DIV_W);
   localparam int PC_W      = 4;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;

   // divide by 5 as a multiply by ceil(2^29/5) and a shift, exact below 2^26
   localparam int KP_RECIP_W = 27;
   localparam int KP_SHIFT   = 29;
   localparam int KP_MUL_W   = DIV_W + KP_RECIP_W;

   localparam logic [9:0]  GAIN_INC_RESET   = 10'd10;
   localparam logic [15:0] WINDOW_RESET     = 16'd400;
   localparam logic [7:0]  NEEDED_RESET     = 8'd10;
   localparam logic [15:0] TOLERANCE_RESET  = 16'd4;
   localparam logic [KP_RECIP_W-1:0] KP_RECIP = 27'd107374183;
   localparam logic [KP_W-1:0]  KI_MAX      = {KP_W{1'b1}};
   localparam logic [GAIN_W-1:0] GAIN_MAX   = {GAIN_W{1'b1}};

   typedef enum logic [1:0] {
      REG_GAIN_INC  = 2'd0,
      REG_WINDOW    = 2'd1,
      REG_NEEDED    = 2'd2,
      REG_TOLERANCE = 2'd3
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_RUN     = 2'd0,
      ST_RESTART = 2'd1,
      ST_DONE    = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_TICK,
      OP_WINDOW,
      OP_SIGN,
      OP_PERIOD,
      OP_STABLE,
      OP_MINMAX,
      OP_KP_LOAD,
      OP_DIV,
      OP_KI_LOAD,
      OP_KI_STORE,
      OP_KD_STORE,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      JC_NEVER,
      JC_ALWAYS,
      JC_NO_ACCEPT,
      JC_DONE,
      JC_RESTART,
      JC_NO_PERIOD,
      JC_FINISHED,
      JC_DIV_BUSY,
      JC_RSP_BUSY
   } jc_type;

   typedef struct packed {
      op_type           op;
      jc_type           jc;
      logic [PC_W-1:0]  target;
   } ctrl_type;

   localparam logic [PC_W-1:0] STEP_WAIT     = 4'd0;
   localparam logic [PC_W-1:0] STEP_TICK     = 4'd1;
   localparam logic [PC_W-1:0] STEP_WINDOW   = 4'd2;
   localparam logic [PC_W-1:0] STEP_SIGN     = 4'd3;
   localparam logic [PC_W-1:0] STEP_PERIOD   = 4'd4;
   localparam logic [PC_W-1:0] STEP_STABLE   = 4'd5;
   localparam logic [PC_W-1:0] STEP_MINMAX   = 4'd6;
   localparam logic [PC_W-1:0] STEP_KP_LOAD  = 4'd7;
   localparam logic [PC_W-1:0] STEP_KI_LOAD  = 4'd8;
   localparam logic [PC_W-1:0] STEP_KI_DIV   = 4'd9;
   localparam logic [PC_W-1:0] STEP_KI_STORE = 4'd10;
   localparam logic [PC_W-1:0] STEP_KD_STORE = 4'd11;
   localparam logic [PC_W-1:0] STEP_EMIT     = 4'd15;

   // microcode: fall through to pc+1 unless the jump condition holds
   function automatic ctrl_type ucode(input logic [PC_W-1:0] pc);
      ctrl_type w;
      case (pc)
         STEP_WAIT:     w = '{OP_ACCEPT,   JC_NO_ACCEPT, STEP_WAIT};
         STEP_TICK:     w = '{OP_TICK,     JC_DONE,      STEP_EMIT};
         STEP_WINDOW:   w = '{OP_WINDOW,   JC_RESTART,   STEP_EMIT};
         STEP_SIGN:     w = '{OP_SIGN,     JC_NO_PERIOD, STEP_MINMAX};
         STEP_PERIOD:   w = '{OP_PERIOD,   JC_NEVER,     STEP_WAIT};
         STEP_STABLE:   w = '{OP_STABLE,   JC_FINISHED,  STEP_KP_LOAD};
         STEP_MINMAX:   w = '{OP_MINMAX,   JC_ALWAYS,    STEP_EMIT};
         STEP_KP_LOAD:  w = '{OP_KP_LOAD,  JC_NEVER,     STEP_WAIT};
         STEP_KI_LOAD:  w = '{OP_KI_LOAD,  JC_NEVER,     STEP_WAIT};
         STEP_KI_DIV:   w = '{OP_DIV,      JC_DIV_BUSY,  STEP_KI_DIV};
         STEP_KI_STORE: w = '{OP_KI_STORE, JC_NEVER,     STEP_WAIT};
         STEP_KD_STORE: w = '{OP_KD_STORE, JC_ALWAYS,    STEP_EMIT};
         // wraps to the wait step once the result register is free
         STEP_EMIT:     w = '{OP_EMIT,     JC_RSP_BUSY,  STEP_EMIT};
         default:       w = '{OP_NONE,     JC_ALWAYS,    STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// File: sv/ziegler_nichols_oscillation_tuner.sv
// top level: microcoded ultimate-gain autotuner with csr block
//
//  channel  | direction | handshake                    | payload
//  req_     | in        | req_valid / req_ready        | error_sample (s16 Q4.12)
//  rsp_     | out       | rsp_valid / rsp_ready        | status, gain, period, amplitude, gains
//  csr_     | in/out    | psel/penable/pwrite, pready=1| paddr[3:0], pwdata/prdata 32 bit
//
// a running sample goes through the tick, window, sign and min/max steps to emit; one that
// closes a period adds the period and stability steps; a window restart or done tuner skips to
// emit, then wraps to the wait step; the sample that finishes tuning does kp by reciprocal multiply,
// then a 26-step restoring division for ki (4*kp+Tu over 2*Tu) and a 24x16 multiply for kd
// req_ready is high only in the wait step; one beat is in flight at a time
// the result register holds a beat until taken; the emit step stalls while it is full
// synchronous active-high reset restores the registers and tracking state
`timescale 1ns / 1ps
`default_nettype none
module ziegler_nichols_oscillation_tuner (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [zn_tune_pkg::SAMPLE_W-1:0] req_error_sample,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [1:0]                                rsp_status,
   output logic [zn_tune_pkg::GAIN_W-1:0]            rsp_gain_under_test,
   output logic [zn_tune_pkg::TICK_W-1:0]            rsp_period_ticks,
   output logic [15:0]                               rsp_amplitude,
   output logic [zn_tune_pkg::KP_W-1:0]              rsp_tuned_kp,
   output logic [zn_tune_pkg::KP_W-1:0]              rsp_tuned_ki,
   output logic [zn_tune_pkg::KD_W-1:0]              rsp_tuned_kd,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [zn_tune_pkg::CSR_AW-1:0]       csr_paddr,
   input  wire logic [zn_tune_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic [zn_tune_pkg::CSR_DW-1:0]            csr_prdata,
   output logic                                      csr_pready
);
   import zn_tune_pkg::*;

   // control
   logic [PC_W-1:0]   pc_ff, pc_in;
   ctrl_type          ctrl;
   logic              take_jump;

   // configuration
   logic [9:0]        gain_inc_ff, gain_inc_in;
   logic [15:0]       window_ff, window_in;
   logic [7:0]        needed_ff, needed_in;
   logic [15:0]       tol_ff, tol_in;

   // tracking state
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [TICK_W-1:0] lps_ff, lps_in;
   logic              last_neg_ff, last_neg_in;
   logic              parity_ff, parity_in;
   logic [7:0]        stable_ff, stable_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;
   logic signed [SAMPLE_W-1:0] max_ff, max_in;
   logic [AMP_W-1:0]  prev_amp_ff, prev_amp_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [TICK_W-1:0] period_ff, period_in;
   logic              done_ff, done_in;

   // datapath
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [AMP_W-1:0]  amp_ff, amp_in;
   status_type        status_ff, status_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [KP_W-1:0]   kp_ff, kp_in;
   logic [KP_W-1:0]   ki_ff, ki_in;
   logic [KD_W-1:0]   kd_ff, kd_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [GAIN_W-1:0] rsp_gain_ff, rsp_gain_in;
   logic [TICK_W-1:0] rsp_period_ff, rsp_period_in;
   logic [15:0]       rsp_amp_ff, rsp_amp_in;
   logic [KP_W-1:0]   rsp_kp_ff, rsp_kp_in;
   logic [KP_W-1:0]   rsp_ki_ff, rsp_ki_in;
   logic [KD_W-1:0]   rsp_kd_ff, rsp_kd_in;

   // decoded conditions
   logic              window_hit;
   logic              sign_hit;
   logic              tol_hit;
   logic              finished;
   logic              rsp_busy;
   logic [GAIN_W:0]   gain_sum;
   logic [AMP_W-1:0]  amp_diff;
   logic [8:0]        stable_n;
   logic [DEN_W:0]    rem_sh;
   logic              div_ge;
   logic              csr_write;
   logic [PROD_W-1:0] kd_sum;
   logic [DIV_W-1:0]  kp_num;
   logic [KP_MUL_W-1:0] kp_mul;

   assign ctrl       = ucode(pc_ff);
   assign req_ready  = (ctrl.op == OP_ACCEPT);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   assign window_hit = (tick_ff == window_ff);
   assign sign_hit   = (sample_ff == '0) || (sample_ff[SAMPLE_W-1] != last_neg_ff);
   assign amp_diff   = (amp_ff >= prev_amp_ff) ? amp_ff - prev_amp_ff : prev_amp_ff - amp_ff;
   assign tol_hit    = amp_diff < {1'b0, tol_ff};
   assign stable_n   = {1'b0, stable_ff} + 9'd1;
   assign finished   = tol_hit && (stable_n > {1'b0, needed_ff});
   assign rsp_busy   = rsp_valid_ff && !rsp_ready;
   assign gain_sum   = {1'b0, gain_ff} + (GAIN_W + 1)'(gain_inc_ff);
   assign rem_sh     = {rem_ff, num_ff[DIV_W-1]};
   assign div_ge     = rem_sh >= {1'b0, den_ff};
   assign kd_sum     = prod_ff + PROD_W'(4);

   // p*768 + 2, then divide by 5 for round(0.6*p*256)
   assign kp_num = DIV_W'({gain_ff, 9'b0}) + DIV_W'({gain_ff, 8'b0}) + DIV_W'(2);
   assign kp_mul = KP_MUL_W'(kp_num) * KP_MUL_W'(KP_RECIP);

   always_comb begin
      case (ctrl.jc)
         JC_NEVER:     take_jump = 1'b0;
         JC_ALWAYS:    take_jump = 1'b1;
         JC_NO_ACCEPT: take_jump = !req_valid;
         JC_DONE:      take_jump = done_ff;
         JC_RESTART:   take_jump = window_hit;
         JC_NO_PERIOD: take_jump = !(sign_hit && parity_ff);
         JC_FINISHED:  take_jump = finished;
         JC_DIV_BUSY:  take_jump = (cnt_ff != '0);
         JC_RSP_BUSY:  take_jump = rsp_busy;
         default:      take_jump = 1'b0;
      endcase
   end

   always_comb begin
      pc_in         = take_jump ? ctrl.target : pc_ff + PC_W'(1);

      gain_inc_in   = gain_inc_ff;
      window_in     = window_ff;
      needed_in     = needed_ff;
      tol_in        = tol_ff;

      tick_in       = tick_ff;
      lps_in        = lps_ff;
      last_neg_in   = last_neg_ff;
      parity_in     = parity_ff;
      stable_in     = stable_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      prev_amp_in   = prev_amp_ff;
      gain_in       = gain_ff;
      period_in     = period_ff;
      done_in       = done_ff;

      sample_in     = sample_ff;
      amp_in        = amp_ff;
      status_in     = status_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      cnt_in        = cnt_ff;
      kp_in         = kp_ff;
      ki_in         = ki_ff;
      kd_in         = kd_ff;
      prod_in       = prod_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_gain_in   = rsp_gain_ff;
      rsp_period_in = rsp_period_ff;
      rsp_amp_in    = rsp_amp_ff;
      rsp_kp_in     = rsp_kp_ff;
      rsp_ki_in     = rsp_ki_ff;
      rsp_kd_in     = rsp_kd_ff;

      if (csr_write) begin
         case (reg_idx_type'(csr_paddr[3:2]))
            REG_GAIN_INC:  gain_inc_in = csr_pwdata[9:0];
            REG_WINDOW:    window_in   = csr_pwdata[15:0];
            REG_NEEDED:    needed_in   = csr_pwdata[7:0];
            REG_TOLERANCE: tol_in      = csr_pwdata[15:0];
            default:       ;
         endcase
      end

      case (ctrl.op)
         OP_ACCEPT: begin
            if (req_valid) sample_in = req_error_sample;
         end
         OP_TICK: begin
            if (done_ff) begin
               status_in = ST_DONE;
            end else begin
               tick_in   = tick_ff + TICK_W'(1);
               status_in = ST_RUN;
            end
         end
         OP_WINDOW: begin
            if (window_hit) begin
               gain_in     = gain_sum[GAIN_W] ? GAIN_MAX : gain_sum[GAIN_W-1:0];
               tick_in     = '0;
               lps_in      = '0;
               last_neg_in = 1'b1;
               parity_in   = 1'b0;
               stable_in   = '0;
               min_in      = '0;
               max_in      = '0;
               prev_amp_in = '0;
               status_in   = ST_RESTART;
            end
         end
         OP_SIGN: begin
            if (sign_hit) begin
               last_neg_in = sample_ff[SAMPLE_W-1];
               parity_in   = !parity_ff;
            end
         end
         OP_PERIOD: begin
            amp_in    = AMP_W'({max_ff[SAMPLE_W-1], max_ff}) -
                        AMP_W'({min_ff[SAMPLE_W-1], min_ff});
            period_in = tick_ff - lps_ff;
            lps_in    = tick_ff;
         end
         OP_STABLE: begin
            prev_amp_in = amp_ff;
            if (tol_hit) begin
               stable_in = stable_n[8] ? 8'hFF : stable_n[7:0];
               if (finished) begin
                  done_in   = 1'b1;
                  status_in = ST_DONE;
               end
            end else begin
               stable_in = '0;
            end
         end
         OP_MINMAX: begin
            if (sample_ff < min_ff) min_in = sample_ff;
            else if (sample_ff > max_ff) max_in = sample_ff;
         end
         OP_KP_LOAD: begin
            kp_in = kp_mul[KP_SHIFT +: KP_W];
         end
         OP_DIV: begin
            rem_in = div_ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
            num_in = {num_ff[DIV_W-2:0], div_ge};
            if (cnt_ff != '0) cnt_in = cnt_ff - CNT_W'(1);
         end
         OP_KI_LOAD: begin
            num_in = {kp_ff, 2'b00} + DIV_W'(period_ff);
            den_in = {period_ff, 1'b0};
            rem_in = '0;
            cnt_in = CNT_W'(DIV_W - 1);
         end
         OP_KI_STORE: begin
            // zero period has no valid quotient, report saturation
            ki_in   = ((period_ff == '0) || (num_ff[DIV_W-1:KP_W] != '0)) ?
                      KI_MAX : num_ff[KP_W-1:0];
            prod_in = PROD_W'(kp_ff) * PROD_W'(period_ff);
         end
         OP_KD_STORE: begin
            kd_in = kd_sum[PROD_W-1:3];
         end
         OP_EMIT: begin
            if (!rsp_busy) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_gain_in   = gain_ff;
               rsp_period_in = period_ff;
               rsp_amp_in    = prev_amp_ff[15:0];
               rsp_kp_in     = (status_ff == ST_DONE) ? kp_ff : '0;
               rsp_ki_in     = (status_ff == ST_DONE) ? ki_ff : '0;
               rsp_kd_in     = (status_ff == ST_DONE) ? kd_ff : '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_WAIT;
         gain_inc_ff  <= GAIN_INC_RESET;
         window_ff    <= WINDOW_RESET;
         needed_ff    <= NEEDED_RESET;
         tol_ff       <= TOLERANCE_RESET;
         tick_ff      <= '0;
         lps_ff       <= '0;
         last_neg_ff  <= 1'b1;
         parity_ff    <= 1'b0;
         stable_ff    <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         prev_amp_ff  <= '0;
         gain_ff      <= GAIN_W'(GAIN_INC_RESET);
         period_ff    <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         gain_inc_ff  <= gain_inc_in;
         window_ff    <= window_in;
         needed_ff    <= needed_in;
         tol_ff       <= tol_in;
         tick_ff      <= tick_in;
         lps_ff       <= lps_in;
         last_neg_ff  <= last_neg_in;
         parity_ff    <= parity_in;
         stable_ff    <= stable_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         prev_amp_ff  <= prev_amp_in;
         gain_ff      <= gain_in;
         period_ff    <= period_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      amp_ff        <= amp_in;
      status_ff     <= status_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      cnt_ff        <= cnt_in;
      kp_ff         <= kp_in;
      ki_ff         <= ki_in;
      kd_ff         <= kd_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_gain_ff   <= rsp_gain_in;
      rsp_period_ff <= rsp_period_in;
      rsp_amp_ff    <= rsp_amp_in;
      rsp_kp_ff     <= rsp_kp_in;
      rsp_ki_ff     <= rsp_ki_in;
      rsp_kd_ff     <= rsp_kd_in;
   end

   always_comb begin
      case (reg_idx_type'(csr_paddr[3:2]))
         REG_GAIN_INC:  csr_prdata = CSR_DW'(gain_inc_ff);
         REG_WINDOW:    csr_prdata = CSR_DW'(window_ff);
         REG_NEEDED:    csr_prdata = CSR_DW'(needed_ff);
         REG_TOLERANCE: csr_prdata = CSR_DW'(tol_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_gain_under_test = rsp_gain_ff;
   assign rsp_period_ticks    = rsp_period_ff;
   assign rsp_amplitude       = rsp_amp_ff;
   assign rsp_tuned_kp        = rsp_kp_ff;
   assign rsp_tuned_ki        = rsp_ki_ff;
   assign rsp_tuned_kd        = rsp_kd_ff;

endmodule
`default_nettype wire

// File: sv/zn_tune_checker.sv
// port-level checker for the autotuner, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module zn_tune_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [1:0]                        rsp_status,
   input wire logic [15:0]                       rsp_amplitude,
   input wire logic [zn_tune_pkg::KP_W-1:0]      rsp_tuned_kp,
   input wire logic [zn_tune_pkg::KP_W-1:0]      rsp_tuned_ki,
   input wire logic [zn_tune_pkg::KD_W-1:0]      rsp_tuned_kd
);
   import zn_tune_pkg::*;

   logic            seen_done_ff, seen_done_in;
   logic [KP_W-1:0] seen_kp_ff, seen_kp_in;
   logic            done_beat;

   assign done_beat = rsp_valid && rsp_ready && (rsp_status == ST_DONE);

   always_comb begin
      seen_done_in = seen_done_ff || done_beat;
      seen_kp_in   = done_beat ? rsp_tuned_kp : seen_kp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_done_ff <= 1'b0;
      end else begin
         seen_done_ff <= seen_done_in;
      end
      seen_kp_ff <= seen_kp_in;
   end

   // gains are only reported once tuning is finished
   a_gains_zero_until_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DONE) |->
         (rsp_tuned_kp == '0) && (rsp_tuned_ki == '0) && (rsp_tuned_kd == '0))
      else $error("tuned gains nonzero before tuning done");

   // a restart clears the amplitude history
   a_restart_clears_amp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_RESTART) |-> (rsp_amplitude == '0))
      else $error("restart beat carries stale amplitude");

   // once done, every later beat stays done and repeats the same kp
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_done_ff |-> (rsp_status == ST_DONE) && (rsp_tuned_kp == seen_kp_ff))
      else $error("result changed after tuning done");

   a_rsp_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_tuned_kd))
      else $error("result beat changed while stalled");

endmodule

bind ziegler_nichols_oscillation_tuner zn_tune_checker u_zn_tune_checker (.*);
`default_nettype wire
